>>> hdl/plc_pkg.sv
// shared types, codes and widths for the piecewise-linear calibration block
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

   typedef logic signed [15:0] value_type;
   typedef logic [2:0]         how_type;
   typedef logic [5:0]         slot_type;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_CONVERT = 1'b1;

   localparam how_type HOW_EXACT  = 3'd0;
   localparam how_type HOW_INTERP = 3'd1;
   localparam how_type HOW_LOW    = 3'd2;
   localparam how_type HOW_HIGH   = 3'd3;
   localparam how_type HOW_HELD   = 3'd4;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 1'b1;

   localparam logic [CSR_DATA_W-1:0] ENTRIES_RESET = 7'd26;
   localparam logic                  MODE_RESET    = 1'b1;
   localparam logic                  MODE_CLAMP    = 1'b1;
   localparam int                    MIN_ENTRIES   = 2;

   // one table entry holds x in the upper half and y in the lower half
   localparam int ENTRY_W = 32;

   // |dy|*100 fits 23 bits, |slope|*(sample-x) fits 39 bits
   localparam int SLOPE_W     = 23;
   localparam int DIV_W       = 39;
   localparam int DVS_W       = 16;
   localparam int SHORT_STEPS = 24;
   localparam int STEP_W      = $clog2(DIV_W + 1);
   localparam int SCALE       = 100;

   // a product at or above the cap saturates the result whatever y is
   localparam int               CAP_W    = 23;
   localparam logic [CAP_W-1:0] TERM_CAP = CAP_W'(SCALE * 65536);

   // x / 100 equals (x * RECIP_MUL) >> RECIP_SHIFT for every x up to the cap
   localparam int                 RECIP_W     = 24;
   localparam logic [RECIP_W-1:0] RECIP_MUL   = 24'd10737419;
   localparam int                 RECIP_SHIFT = 30;

   typedef struct packed {
      logic              start;
      logic              short_op;
      logic [DIV_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIV_W-1:0]  quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> hdl/plc_if.sv
// request and response channel interfaces of the calibration block
`timescale 1ns / 1ps
`default_nettype none

interface plc_req_if;
   import plc_pkg::*;

   logic      valid;
   logic      ready;
   logic      op;
   slot_type  entry_index;
   value_type point_x;
   value_type point_y;
   value_type sample;

   modport source (output valid, op, entry_index, point_x, point_y, sample, input ready);
   modport sink   (input valid, op, entry_index, point_x, point_y, sample, output ready);
endinterface

interface plc_rsp_if;
   import plc_pkg::*;

   logic      valid;
   logic      ready;
   value_type calibrated;
   how_type   how_found;
   logic      saturated;

   modport source (output valid, calibrated, how_found, saturated, input ready);
   modport sink   (input valid, calibrated, how_found, saturated, output ready);
endinterface

`default_nettype wire

>>> hdl/plc_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module plc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hdl/plc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module plc_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire plc_pkg::div_req_type div_req,
   output plc_pkg::div_rsp_type      div_rsp
);
   import plc_pkg::*;

   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         busy_in = 1'b1;
         // narrow dividends are left-aligned so fewer steps are needed
         if (div_req.short_op) begin
            quo_in = div_req.dividend << (DIV_W - SHORT_STEPS);
            cnt_in = STEP_W'(SHORT_STEPS);
         end else begin
            quo_in = div_req.dividend;
            cnt_in = STEP_W'(DIV_W);
         end
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> hdl/piecewise_linear_calibration_top.sv
// piecewise-linear calibration: breakpoint table in ram, serial scan, bit-serial divider
//
//   channel   dir   handshake          payload
//   req_if    in    valid / ready      op, entry_index, point_x, point_y, sample
//   rsp_if    out   valid / ready      calibrated, how_found, saturated
//   csr_*     in    csr_we             csr_index, csr_wdata
//
// a load item writes its entry and the block stays ready; a convert item scans the table
// one entry per cycle through the ram read port and stops at an exact hit or a segment hit,
// or at the last of the n entries in use with a clamp or a hold
// an interpolation then runs 24 bit-serial divider steps for the slope, then a
// multiply, a reciprocal multiply for the scaling by 100 and the saturating sum
// synchronous reset clears control and config; the table is undefined until loaded
// a finished result waits in the output register while the next item is accepted; a
// second result stalls in the done state until the output register drains
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_calibration_top #(
   parameter int MAX_ENTRIES = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   plc_req_if.sink                               req_if,
   plc_rsp_if.source                             rsp_if,
   input  wire logic                             csr_we,
   input  wire logic [plc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [plc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import plc_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DIV1  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_SCALE = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   // control
   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         n_ff, n_in;
   logic [CW-1:0]         issue_ff, issue_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [CW-1:0]         rd_idx_ff, rd_idx_in;
   logic                  div_go_ff, div_go_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   value_type             last_result_ff, last_result_in;
   logic [CSR_DATA_W-1:0] entries_ff, entries_in;
   logic                  mode_ff, mode_in;

   // datapath
   value_type             sample_ff, sample_in;
   value_type             prev_x_ff, prev_x_in;
   value_type             prev_y_ff, prev_y_in;
   value_type             first_x_ff, first_x_in;
   value_type             first_y_ff, first_y_in;
   value_type             seg_y0_ff, seg_y0_in;
   logic [15:0]           delta_ff, delta_in;
   logic [DVS_W-1:0]      dx_ff, dx_in;
   logic [15:0]           dy_mag_ff, dy_mag_in;
   logic                  dy_neg_ff, dy_neg_in;
   logic [SLOPE_W-1:0]    slope_ff, slope_in;
   logic [DIV_W-1:0]      prod_ff, prod_in;
   logic [DIV_W-1:0]      term_ff, term_in;
   value_type             res_value_ff, res_value_in;
   how_type               res_how_ff, res_how_in;
   logic                  res_sat_ff, res_sat_in;
   value_type             rsp_value_ff, rsp_value_in;
   how_type               rsp_how_ff, rsp_how_in;
   logic                  rsp_sat_ff, rsp_sat_in;

   logic                      req_fire;
   logic                      rsp_fire;
   logic                      ram_we;
   logic [ENTRY_W-1:0]        ram_rdata;
   value_type                 cur_x;
   value_type                 cur_y;
   logic [CW-1:0]             n_eff;
   logic                      seg_hit;
   logic [16:0]               dy_wide;
   logic [16:0]               delta_wide;
   logic [16:0]               dx_wide;
   logic signed [40:0]        sum_wide;
   logic [DIV_W-1:0]          dy_scaled;
   logic [CAP_W-1:0]          prod_cap;
   logic [CAP_W+RECIP_W-1:0]  recip_prod;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   assign req_fire = req_if.valid && (state_ff == ST_IDLE);
   assign rsp_fire = rsp_valid_ff && rsp_if.ready;
   assign ram_we   = req_fire && (req_if.op == OP_LOAD)
                     && (32'(req_if.entry_index) < MAX_ENTRIES);

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.calibrated = rsp_value_ff;
   assign rsp_if.how_found  = rsp_how_ff;
   assign rsp_if.saturated  = rsp_sat_ff;

   // table store; loads and scans never overlap, one item is in flight at a time
   plc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (IW'(req_if.entry_index)),
      .wdata ({req_if.point_x, req_if.point_y}),
      .raddr (issue_ff[IW-1:0]),
      .rdata (ram_rdata)
   );

   assign cur_x = ram_rdata[ENTRY_W-1:16];
   assign cur_y = ram_rdata[15:0];

   always_comb begin
      if (32'(entries_ff) > MAX_ENTRIES) begin
         n_eff = CW'(MAX_ENTRIES);
      end else if (32'(entries_ff) < MIN_ENTRIES) begin
         n_eff = CW'(MIN_ENTRIES);
      end else begin
         n_eff = CW'(entries_ff);
      end
   end

   assign seg_hit    = (rd_idx_ff != '0) && (sample_ff > prev_x_ff) && (sample_ff < cur_x);
   assign dy_wide    = {cur_y[15], cur_y} - {prev_y_ff[15], prev_y_ff};
   assign delta_wide = {sample_ff[15], sample_ff} - {prev_x_ff[15], prev_x_ff};
   assign dx_wide    = {cur_x[15], cur_x} - {prev_x_ff[15], prev_x_ff};

   // |dy| * 100 as shifts and adds
   assign dy_scaled = DIV_W'({dy_mag_ff, 6'b0}) + DIV_W'({dy_mag_ff, 5'b0})
                      + DIV_W'({dy_mag_ff, 2'b0});

   // only the slope needs the divider; the scaling by 100 is a reciprocal multiply
   assign div_req.start    = div_go_ff;
   assign div_req.short_op = 1'b1;
   assign div_req.dividend = dy_scaled;
   assign div_req.divisor  = dx_ff;

   plc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // larger products saturate anyway, so the cap keeps the reciprocal exact
   assign prod_cap   = (prod_ff >= DIV_W'(TERM_CAP)) ? TERM_CAP : prod_ff[CAP_W-1:0];
   assign recip_prod = prod_cap * RECIP_MUL;

   always_comb begin
      if (dy_neg_ff) begin
         sum_wide = $signed({{25{seg_y0_ff[15]}}, seg_y0_ff}) - $signed({2'b00, term_ff});
      end else begin
         sum_wide = $signed({{25{seg_y0_ff[15]}}, seg_y0_ff}) + $signed({2'b00, term_ff});
      end
   end

   always_comb begin
      state_in       = state_ff;
      n_in           = n_ff;
      issue_in       = issue_ff;
      rd_valid_in    = 1'b0;
      rd_idx_in      = rd_idx_ff;
      div_go_in      = 1'b0;
      rsp_valid_in   = rsp_valid_ff;
      last_result_in = last_result_ff;
      entries_in     = entries_ff;
      mode_in        = mode_ff;
      sample_in      = sample_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      first_x_in     = first_x_ff;
      first_y_in     = first_y_ff;
      seg_y0_in      = seg_y0_ff;
      delta_in       = delta_ff;
      dx_in          = dx_ff;
      dy_mag_in      = dy_mag_ff;
      dy_neg_in      = dy_neg_ff;
      slope_in       = slope_ff;
      prod_in        = prod_ff;
      term_in        = term_ff;
      res_value_in   = res_value_ff;
      res_how_in     = res_how_ff;
      res_sat_in     = res_sat_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_how_in     = rsp_how_ff;
      rsp_sat_in     = rsp_sat_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_ENTRIES: entries_in = csr_wdata;
            CSR_MODE:    mode_in    = csr_wdata[0];
            default:     ;
         endcase
      end

      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_if.op == OP_CONVERT)) begin
               sample_in = req_if.sample;
               n_in      = n_eff;
               issue_in  = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff < n_ff) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = issue_ff;
               issue_in    = issue_ff + CW'(1);
            end
            if (rd_valid_ff) begin
               prev_x_in = cur_x;
               prev_y_in = cur_y;
               if (rd_idx_ff == '0) begin
                  first_x_in = cur_x;
                  first_y_in = cur_y;
               end
               // segment to the previous entry is checked before an exact hit on this one
               if (seg_hit) begin
                  seg_y0_in = prev_y_ff;
                  delta_in  = delta_wide[15:0];
                  dx_in     = dx_wide[DVS_W-1:0];
                  dy_neg_in = dy_wide[16];
                  dy_mag_in = dy_wide[16] ? 16'(-dy_wide) : dy_wide[15:0];
                  div_go_in = 1'b1;
                  state_in  = ST_DIV1;
               end else if (sample_ff == cur_x) begin
                  res_value_in = cur_y;
                  res_how_in   = HOW_EXACT;
                  res_sat_in   = 1'b0;
                  state_in     = ST_DONE;
               end else if (rd_idx_ff == n_ff - CW'(1)) begin
                  res_sat_in = 1'b0;
                  state_in   = ST_DONE;
                  if ((mode_ff == MODE_CLAMP) && (sample_ff < first_x_ff)) begin
                     res_value_in = first_y_ff;
                     res_how_in   = HOW_LOW;
                  end else if ((mode_ff == MODE_CLAMP) && (sample_ff > cur_x)) begin
                     res_value_in = cur_y;
                     res_how_in   = HOW_HIGH;
                  end else begin
                     // outside with hold mode, or a gap in a table that is not ascending
                     res_value_in = last_result_ff;
                     res_how_in   = HOW_HELD;
                  end
               end
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               slope_in = div_rsp.quotient[SLOPE_W-1:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = slope_ff * delta_ff;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            term_in  = DIV_W'(recip_prod[CAP_W+RECIP_W-1:RECIP_SHIFT]);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            res_how_in = HOW_INTERP;
            if (sum_wide > 41'sd32767) begin
               res_value_in = 16'sh7fff;
               res_sat_in   = 1'b1;
            end else if (sum_wide < -41'sd32768) begin
               res_value_in = 16'sh8000;
               res_sat_in   = 1'b1;
            end else begin
               res_value_in = sum_wide[15:0];
               res_sat_in   = 1'b0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_value_in   = res_value_ff;
               rsp_how_in     = res_how_ff;
               rsp_sat_in     = res_sat_ff;
               last_result_in = res_value_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         n_ff           <= CW'(MIN_ENTRIES);
         issue_ff       <= '0;
         rd_valid_ff    <= 1'b0;
         rd_idx_ff      <= '0;
         div_go_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_result_ff <= '0;
         entries_ff     <= ENTRIES_RESET;
         mode_ff        <= MODE_RESET;
      end else begin
         state_ff       <= state_in;
         n_ff           <= n_in;
         issue_ff       <= issue_in;
         rd_valid_ff    <= rd_valid_in;
         rd_idx_ff      <= rd_idx_in;
         div_go_ff      <= div_go_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_result_ff <= last_result_in;
         entries_ff     <= entries_in;
         mode_ff        <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      first_x_ff   <= first_x_in;
      first_y_ff   <= first_y_in;
      seg_y0_ff    <= seg_y0_in;
      delta_ff     <= delta_in;
      dx_ff        <= dx_in;
      dy_mag_ff    <= dy_mag_in;
      dy_neg_ff    <= dy_neg_in;
      slope_ff     <= slope_in;
      prod_ff      <= prod_in;
      term_ff      <= term_in;
      res_value_ff <= res_value_in;
      res_how_ff   <= res_how_in;
      res_sat_ff   <= res_sat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_how_ff   <= rsp_how_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // table reads stay inside the entries in use
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (rd_idx_ff < n_ff))
      else $error("table read beyond entries in use");

   // the divider is never restarted while a division runs
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV1))
      else $error("divider finished outside the divide state");

   // the pending result is always the remembered last result
   a_last_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff == last_result_ff))
      else $error("last result differs from pending response");

   a_sat_interp_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_how_ff != HOW_INTERP)) |-> !rsp_sat_ff)
      else $error("saturation flagged on a non-interpolated result");

endmodule

`default_nettype wire
